FILE: rtl/core/apmh_pkg.sv
// -----------------------------------------------------------------------------
// apmh_pkg
// Shared types and codes for the actuator position mover: item layouts,
// command and mode codes, configuration register map.
// -----------------------------------------------------------------------------
package apmh_pkg;

    typedef enum logic [1:0] {
        CMD_ENC_SAMPLE = 2'd0,
        CMD_STALL_TICK = 2'd1,
        CMD_MOVE       = 2'd2,
        CMD_HOME       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE         = 2'd0,
        MODE_MOVE         = 2'd1,
        MODE_HOME_RETRACT = 2'd2,
        MODE_HOME_EXTEND  = 2'd3
    } t_mode;

    // register index on the configuration port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_PULSE_STEP      = 2'd0,
        REG_DECEL_ALLOWANCE = 2'd1,
        REG_DRIVE_POWER     = 2'd2,
        REG_HOME_OFFSET     = 2'd3
    } t_reg_idx;

    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DIST_W     = 23;
    localparam int unsigned OUT_POS_W  = 24;

    typedef struct packed {
        t_cmd                cmd;
        logic                enc_a;
        logic                enc_b;
        logic [DIST_W-1:0]   move_distance;
        logic                move_extend;
    } t_in_item;

    typedef struct packed {
        logic                        drive_out;
        logic                        drive_in;
        logic [7:0]                  drive_level;
        logic signed [OUT_POS_W-1:0] position_now;
        logic                        busy_res;
        logic                        move_done;
        logic                        homed;
        logic                        rejected;
    } t_out_item;

    typedef struct packed {
        logic [15:0] pulse_step;
        logic [15:0] decel_allowance;
        logic [7:0]  drive_power;
        logic [15:0] home_offset;
    } t_cfg;

endpackage

FILE: rtl/core/apmh_regs.sv
// -----------------------------------------------------------------------------
// apmh_regs
// APB register file holding step size, decel allowance, drive power and
// homing offset.
// -----------------------------------------------------------------------------
module apmh_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apmh_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output apmh_pkg::t_cfg                 o_cfg
);

    apmh_pkg::t_cfg     r_cfg;
    apmh_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = apmh_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_step      <= 16'd16;
            r_cfg.decel_allowance <= 16'd0;
            r_cfg.drive_power     <= 8'd255;
            r_cfg.home_offset     <= 16'd256;
        end else if (w_wr) begin
            unique case (w_idx)
                apmh_pkg::REG_PULSE_STEP:      r_cfg.pulse_step      <= pwdata[15:0];
                apmh_pkg::REG_DECEL_ALLOWANCE: r_cfg.decel_allowance <= pwdata[15:0];
                apmh_pkg::REG_DRIVE_POWER:     r_cfg.drive_power     <= pwdata[7:0];
                apmh_pkg::REG_HOME_OFFSET:     r_cfg.home_offset     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            apmh_pkg::REG_PULSE_STEP:      prdata = {16'd0, r_cfg.pulse_step};
            apmh_pkg::REG_DECEL_ALLOWANCE: prdata = {16'd0, r_cfg.decel_allowance};
            apmh_pkg::REG_DRIVE_POWER:     prdata = {24'd0, r_cfg.drive_power};
            apmh_pkg::REG_HOME_OFFSET:     prdata = {16'd0, r_cfg.home_offset};
            default:                       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/apmh_core.sv
// -----------------------------------------------------------------------------
// apmh_core
// Position counter, move/homing sequencer and result formation. State is
// updated on each accepted item; the result for that item is combinational.
// -----------------------------------------------------------------------------
module apmh_core #(
    parameter int unsigned POS_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  apmh_pkg::t_in_item   i_item,
    input  apmh_pkg::t_cfg       i_cfg,
    output apmh_pkg::t_out_item  o_result
);

    // working width covers position, 23-bit distance and one carry each way
    localparam int unsigned EXT =
        ((POS_WIDTH > apmh_pkg::OUT_POS_W) ? POS_WIDTH : apmh_pkg::OUT_POS_W) + 2;
    localparam logic signed [EXT-1:0] POS_HI =
        {{(EXT-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [EXT-1:0] POS_LO = ~POS_HI;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [EXT-1:0] v
    );
        logic signed [EXT-1:0] s;
        if (v > POS_HI)      s = POS_HI;
        else if (v < POS_LO) s = POS_LO;
        else                 s = v;
        return s[POS_WIDTH-1:0];
    endfunction

    apmh_pkg::t_mode               r_mode, n_mode, w_mode_a;
    logic signed [POS_WIDTH-1:0]   r_pos, n_pos, w_pos_a;
    logic signed [POS_WIDTH-1:0]   r_target, n_target;
    logic signed [POS_WIDTH-1:0]   r_last_tick, n_last_tick;
    logic                          r_prev_a, r_prev_b, n_prev_a, n_prev_b;
    logic                          r_heading, n_heading;
    logic                          r_tick_seen, n_tick_seen;
    logic                          r_homed, n_homed;

    logic signed [EXT-1:0]         w_pos_x, w_dist_x, w_allow_x, w_step_x, w_off_x;
    logic signed [EXT-1:0]         w_len_x, w_delta, w_retract_chk;
    logic signed [POS_WIDTH-1:0]   w_new_target;
    logic                          w_start_move, w_start_home, w_stall_hit, w_reject;
    logic                          w_set_target, w_tgt_extend, w_reached, w_done;
    logic                          w_inc, w_dec;
    logic signed [EXT-1:0]         w_pos_out_x;

    // ---------------- datapath ----------------
    assign w_pos_x   = {{(EXT-POS_WIDTH){r_pos[POS_WIDTH-1]}}, r_pos};
    assign w_dist_x  = {{(EXT-apmh_pkg::DIST_W){1'b0}}, i_item.move_distance};
    assign w_allow_x = {{(EXT-16){1'b0}}, i_cfg.decel_allowance};
    assign w_step_x  = {{(EXT-16){1'b0}}, i_cfg.pulse_step};
    assign w_off_x   = {{(EXT-16){1'b0}}, i_cfg.home_offset};

    // counted falling-edge patterns from the A=1,B=1 state
    assign w_inc = (i_item.cmd == apmh_pkg::CMD_ENC_SAMPLE) & r_prev_a & r_prev_b
                   & ~i_item.enc_a & i_item.enc_b;
    assign w_dec = (i_item.cmd == apmh_pkg::CMD_ENC_SAMPLE) & r_prev_a & r_prev_b
                   & i_item.enc_a & ~i_item.enc_b;

    always_comb begin
        priority if (w_inc) w_pos_a = sat_pos(w_pos_x + w_step_x);
        else if (w_dec)     w_pos_a = sat_pos(w_pos_x - w_step_x);
        else                w_pos_a = r_pos;
    end

    assign w_retract_chk = w_pos_x - w_dist_x;

    // one shared adder for move and home-extend targets; allowance shortens both
    assign w_tgt_extend = (i_item.cmd == apmh_pkg::CMD_STALL_TICK) | i_item.move_extend;
    assign w_len_x      = (i_item.cmd == apmh_pkg::CMD_STALL_TICK) ? w_off_x : w_dist_x;
    assign w_delta      = w_tgt_extend ? (w_len_x - w_allow_x) : (w_allow_x - w_len_x);
    assign w_new_target = sat_pos(w_pos_x + w_delta);

    // ---------------- next state ----------------
    always_comb begin
        w_start_move = 1'b0;
        w_start_home = 1'b0;
        w_stall_hit  = 1'b0;
        w_reject     = 1'b0;
        w_mode_a     = r_mode;
        unique case (i_item.cmd)
            apmh_pkg::CMD_ENC_SAMPLE: ;
            apmh_pkg::CMD_STALL_TICK: begin
                if (r_mode == apmh_pkg::MODE_HOME_RETRACT && r_tick_seen
                    && r_pos == r_last_tick) begin
                    w_stall_hit = 1'b1;
                    w_mode_a    = apmh_pkg::MODE_HOME_EXTEND;
                end
            end
            apmh_pkg::CMD_MOVE: begin
                if (r_mode != apmh_pkg::MODE_IDLE) begin
                    w_reject = 1'b1;
                end else if (!i_item.move_extend && w_retract_chk[EXT-1]) begin
                    w_reject = 1'b1;
                end else begin
                    w_start_move = 1'b1;
                    w_mode_a     = apmh_pkg::MODE_MOVE;
                end
            end
            apmh_pkg::CMD_HOME: begin
                if (r_mode != apmh_pkg::MODE_IDLE) begin
                    w_reject = 1'b1;
                end else begin
                    w_start_home = 1'b1;
                    w_mode_a     = apmh_pkg::MODE_HOME_RETRACT;
                end
            end
            default: ;
        endcase
    end

    assign w_done = w_reached & ((w_mode_a == apmh_pkg::MODE_MOVE)
                               | (w_mode_a == apmh_pkg::MODE_HOME_EXTEND));
    assign n_mode = w_done ? apmh_pkg::MODE_IDLE : w_mode_a;

    assign w_set_target = w_start_move | w_stall_hit;

    always_comb begin
        n_heading   = r_heading;
        n_target    = r_target;
        n_tick_seen = r_tick_seen;
        n_last_tick = r_last_tick;
        n_prev_a    = r_prev_a;
        n_prev_b    = r_prev_b;
        if (i_item.cmd == apmh_pkg::CMD_ENC_SAMPLE) begin
            n_prev_a = i_item.enc_a;
            n_prev_b = i_item.enc_b;
        end
        if (w_set_target) begin
            n_heading = w_tgt_extend;
            n_target  = w_new_target;
        end
        if (w_start_home) begin
            n_heading   = 1'b0;
            n_tick_seen = 1'b0;
        end
        if (i_item.cmd == apmh_pkg::CMD_STALL_TICK
            && r_mode == apmh_pkg::MODE_HOME_RETRACT && !w_stall_hit) begin
            n_last_tick = r_pos;
            n_tick_seen = 1'b1;
        end
    end

    always_comb begin
        n_pos   = w_pos_a;
        n_homed = r_homed;
        if (w_done && w_mode_a == apmh_pkg::MODE_HOME_EXTEND) begin
            n_pos   = '0;
            n_homed = 1'b1;
        end
    end

    assign w_reached = n_heading ? (w_pos_a >= n_target) : (w_pos_a <= n_target);

    // ---------------- outputs ----------------
    assign w_pos_out_x = {{(EXT-POS_WIDTH){n_pos[POS_WIDTH-1]}}, n_pos};

    always_comb begin
        o_result.busy_res     = (n_mode != apmh_pkg::MODE_IDLE);
        o_result.drive_out    = o_result.busy_res & n_heading;
        o_result.drive_in     = o_result.busy_res & ~n_heading;
        o_result.drive_level  = o_result.busy_res ? i_cfg.drive_power : 8'd0;
        o_result.position_now = w_pos_out_x[apmh_pkg::OUT_POS_W-1:0];
        o_result.move_done    = w_done;
        o_result.homed        = n_homed;
        o_result.rejected     = w_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= apmh_pkg::MODE_IDLE;
            r_pos       <= '0;
            r_target    <= '0;
            r_last_tick <= '0;
            r_prev_a    <= 1'b0;
            r_prev_b    <= 1'b0;
            r_heading   <= 1'b0;
            r_tick_seen <= 1'b0;
            r_homed     <= 1'b0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_target    <= n_target;
            r_last_tick <= n_last_tick;
            r_prev_a    <= n_prev_a;
            r_prev_b    <= n_prev_b;
            r_heading   <= n_heading;
            r_tick_seen <= n_tick_seen;
            r_homed     <= n_homed;
        end
    end

    a_home_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.cmd == apmh_pkg::CMD_HOME && r_mode == apmh_pkg::MODE_IDLE
        |=> r_mode == apmh_pkg::MODE_HOME_RETRACT && !r_tick_seen && !r_heading)
        else $error("home request from idle did not enter retract");

    a_ext_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == apmh_pkg::MODE_HOME_EXTEND |-> r_heading)
        else $error("home extend phase without extend heading");

    a_homed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homed |=> r_homed)
        else $error("homed flag dropped");

    a_busy_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_mode != apmh_pkg::MODE_IDLE
        && (i_item.cmd == apmh_pkg::CMD_MOVE || i_item.cmd == apmh_pkg::CMD_HOME)
        |-> o_result.rejected && !o_result.move_done)
        else $error("request while busy not rejected");

endmodule

FILE: rtl/core/actuator_position_mover_with_homing.sv
// -----------------------------------------------------------------------------
// actuator_position_mover_with_homing
// Encoder-counting bang-bang position mover with homing sequence.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------
//   in      | sink      | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//   out     | source    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//   cfg     | APB slave | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One item per cycle while the input is not stalled; each item gives one result,
// registered on acceptance and shown in the next cycle.
// Synchronous active-low reset clears position, mode, flags and output valid.
// Input is stalled only while a held result is itself stalled.
// -----------------------------------------------------------------------------
module actuator_position_mover_with_homing #(
    parameter int unsigned POS_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  apmh_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output apmh_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apmh_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    apmh_pkg::t_cfg      w_cfg;
    apmh_pkg::t_out_item w_result;
    apmh_pkg::t_out_item r_out_data;
    logic                r_out_valid;
    logic                w_accept;

    apmh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    apmh_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
